FILE: sv/kcnt_pkg.sv
`timescale 1ns / 1ps

package kcnt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int CNT_W    = 16;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  typedef struct packed {
    op_t                operation;
    logic [KEY_W-1:0]   item_key;
    logic [CNT_W-1:0]   amount;
    logic [INDEX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [CNT_W-1:0]    count_value;
    logic [KEY_W-1:0]    key_at_index;
    logic [TOTAL_W-1:0]  entry_total;
  } res_t;

  // Broadcast to every cell when a transaction is taken.
  typedef struct packed {
    logic               capture;
    logic [KEY_W-1:0]   item_key;
    logic [INDEX_W-1:0] entry_index;
  } cap_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic             update;
    logic [CNT_W-1:0] new_count;
    logic             remove;
    logic [KEY_W-1:0] move_key;
    logic [CNT_W-1:0] move_count;
    logic             append;
    logic [KEY_W-1:0] app_key;
    logic [CNT_W-1:0] app_count;
  } apply_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             pick;
    logic             last;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } view_t;

endpackage

FILE: sv/kcnt_cell.sv
`timescale 1ns / 1ps

module kcnt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [kcnt_pkg::SLOT_W-1:0] position,
  input  logic                        prev_valid,
  input  logic                        next_valid,
  input  kcnt_pkg::cap_t              cap,
  input  kcnt_pkg::apply_t            apply,
  output kcnt_pkg::view_t             view
);
  import kcnt_pkg::*;

  logic             valid;
  logic             hit;
  logic             pick;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count;
  logic             last;
  logic             open_slot;

  // The occupied cells form a packed run from position zero; the neighbors mark its ends.
  assign last      = valid && !next_valid;
  assign open_slot = !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
      pick  <= 1'b0;
    end else begin
      if (cap.capture) begin
        hit  <= valid && (key == cap.item_key);
        pick <= valid && (32'(position) == 32'(cap.entry_index));
      end
      if (apply.remove && last) begin
        valid <= 1'b0;
      end else if (apply.append && open_slot) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply.update && hit) begin
      count <= apply.new_count;
    end
    // Pull the last entry into the freed slot.
    if (apply.remove && hit && !last) begin
      key   <= apply.move_key;
      count <= apply.move_count;
    end
    if (apply.append && open_slot) begin
      key   <= apply.app_key;
      count <= apply.app_count;
    end
  end

  assign view = '{valid: valid, hit: hit, pick: pick, last: last, key: key, count: count};

endmodule

FILE: sv/keyed_count_table_top.sv
`timescale 1ns / 1ps

// Keyed count table: up to TABLE_ENTRIES (key, count) entries kept packed
// from slot zero, one per cell of a chain.
// Request channel: drive request and raise start; the transaction is taken
// at a clock edge where start is high and busy is low. busy is then high
// for the update cycle, while the table is updated.
// Result channel: done rises at the clock edge that ends the update cycle
// and stays high for one cycle; result is registered at that same edge and
// holds status, found flag, count, key and entry total.
// No new transaction is taken during the update cycle. Each cell compares
// the key and index at the request edge; the update cycle that follows
// gathers the matching cell's data, works out the new count and writes
// the cells.
// The receiver cannot hold results off; each result is shown exactly once.
// Reset (rst, synchronous) empties the table and clears any pending result.
// Key and count stores are not cleared; only occupied cells are ever read.
module keyed_count_table_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  kcnt_pkg::req_t  request,
  output logic            done,
  output kcnt_pkg::res_t  result
);
  import kcnt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  req_t              cmd;
  logic [FILL_W-1:0] fill_level;
  logic [FILL_W-1:0] fill_next;
  res_t              res_next;
  logic              take;

  cap_t   cap;
  apply_t apply;
  view_t  views [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] hit_vec;

  logic             any_hit;
  logic [CNT_W-1:0] hit_count;
  logic             any_pick;
  logic [KEY_W-1:0] pick_key;
  logic [CNT_W-1:0] pick_count;
  logic [KEY_W-1:0] last_key;
  logic [CNT_W-1:0] last_count;
  logic [CNT_W:0]   sum;
  logic             full;

  assign busy = (state == S_APPLY);
  assign take = start && !busy;

  assign cap = '{capture: take, item_key: request.item_key, entry_index: request.entry_index};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic prev_v;
    logic next_v;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = views[i-1].valid;
    end
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign next_v = 1'b0;
    end else begin : g_inner
      assign next_v = views[i+1].valid;
    end

    kcnt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .position   (SLOT_W'(i)),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .cap        (cap),
      .apply      (apply),
      .view       (views[i])
    );

    assign valid_vec[i] = views[i].valid;
    assign hit_vec[i]   = views[i].hit;
  end

  // Keys are unique, so at most one cell hits and AND-OR selection is enough.
  always_comb begin
    any_hit    = 1'b0;
    hit_count  = '0;
    any_pick   = 1'b0;
    pick_key   = '0;
    pick_count = '0;
    last_key   = '0;
    last_count = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      any_hit    = any_hit  | views[i].hit;
      any_pick   = any_pick | views[i].pick;
      hit_count  = hit_count  | (views[i].hit  ? views[i].count : '0);
      pick_key   = pick_key   | (views[i].pick ? views[i].key   : '0);
      pick_count = pick_count | (views[i].pick ? views[i].count : '0);
      last_key   = last_key   | (views[i].last ? views[i].key   : '0);
      last_count = last_count | (views[i].last ? views[i].count : '0);
    end
  end

  assign full = (fill_level == FILL_W'(TABLE_ENTRIES));
  assign sum  = {1'b0, hit_count} + {1'b0, cmd.amount};

  always_comb begin
    res_next = '{status: ST_OK, found: 1'b0, count_value: '0, key_at_index: '0,
                 entry_total: '0};
    apply     = '0;
    fill_next = fill_level;

    unique case (cmd.operation)
      OP_ADD: begin
        res_next.found = any_hit;
        if (cmd.amount == '0) begin
          res_next.status      = ST_ZERO;
          res_next.count_value = any_hit ? hit_count : '0;
        end else if (any_hit) begin
          res_next.count_value = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
          apply.update         = 1'b1;
          apply.new_count      = res_next.count_value;
        end else if (full) begin
          res_next.status = ST_FULL;
        end else begin
          apply.append         = 1'b1;
          apply.app_key        = cmd.item_key;
          apply.app_count      = cmd.amount;
          res_next.count_value = cmd.amount;
          fill_next            = fill_level + FILL_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!any_hit) begin
          res_next.status = ST_MISSING;
        end else begin
          res_next.found = 1'b1;
          if (cmd.amount >= hit_count && cmd.amount != '0) begin
            apply.remove     = 1'b1;
            apply.move_key   = last_key;
            apply.move_count = last_count;
            fill_next        = fill_level - FILL_W'(1);
          end else begin
            res_next.count_value = hit_count - cmd.amount;
            apply.update         = 1'b1;
            apply.new_count      = res_next.count_value;
          end
        end
      end
      OP_QUERY: begin
        if (any_hit) begin
          res_next.found       = 1'b1;
          res_next.count_value = hit_count;
        end else begin
          res_next.status = ST_MISSING;
        end
      end
      OP_READ: begin
        if (any_pick) begin
          res_next.key_at_index = pick_key;
          res_next.count_value  = pick_count;
        end else begin
          res_next.status = ST_RANGE;
        end
      end
      default: begin
        res_next.status = ST_OK;
      end
    endcase

    res_next.entry_total = TOTAL_W'(fill_next);

    // Drop all writes outside the update cycle.
    if (state != S_APPLY) begin
      apply     = '0;
      fill_next = fill_level;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (take) state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_level <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      fill_level <= fill_next;
      done       <= (state == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= request;
    end
    if (state == S_APPLY) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill_level))
    else $error("occupied cells disagree with fill level");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(hit_vec))
    else $error("key held in more than one cell");

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("result without an update cycle");

  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("transaction taken without busy cycle");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kcnt_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int POOL_SIZE    = 96;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASE_COUNT  = 8;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

  // Tracks table contents and the results due from the block, in order.
  class table_tracker;
    logic [KEY_W-1:0]   slot_key   [TABLE_ENTRIES];
    logic [CNT_W-1:0]   slot_count [TABLE_ENTRIES];
    logic [TOTAL_W-1:0] fill_level;
    res_t               due_results[$];
    int unsigned        errors;

    function new();
      fill_level = '0;
      errors     = 0;
    endfunction

    function res_t table_outcome(req_t r);
      res_t           o;
      int             slot;
      logic [CNT_W:0] sum;
      o        = '0;
      o.status = ST_OK;
      slot     = -1;
      for (int i = 0; i < fill_level; i++)
        if (slot < 0 && slot_key[i] == r.item_key) slot = i;
      case (r.operation)
        OP_ADD: begin
          o.found = (slot >= 0);
          if (r.amount == '0) begin
            o.status = ST_ZERO;
            if (slot >= 0) o.count_value = slot_count[slot];
          end else if (slot >= 0) begin
            sum = {1'b0, slot_count[slot]} + {1'b0, r.amount};
            o.count_value = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
            slot_count[slot] = o.count_value;
          end else if (fill_level >= TABLE_ENTRIES) begin
            o.status = ST_FULL;
          end else begin
            slot_key[fill_level]   = r.item_key;
            slot_count[fill_level] = r.amount;
            fill_level++;
            o.count_value = r.amount;
          end
        end
        OP_REMOVE: begin
          if (slot < 0) begin
            o.status = ST_MISSING;
          end else begin
            o.found = 1'b1;
            if (r.amount != '0 && r.amount >= slot_count[slot]) begin
              // delete: the last entry fills the hole
              slot_key[slot]   = slot_key[fill_level - 1];
              slot_count[slot] = slot_count[fill_level - 1];
              fill_level--;
            end else begin
              slot_count[slot] = slot_count[slot] - r.amount;
              o.count_value    = slot_count[slot];
            end
          end
        end
        OP_QUERY: begin
          if (slot >= 0) begin
            o.found       = 1'b1;
            o.count_value = slot_count[slot];
          end else begin
            o.status = ST_MISSING;
          end
        end
        default: begin
          if (r.entry_index < fill_level) begin
            o.key_at_index = slot_key[r.entry_index];
            o.count_value  = slot_count[r.entry_index];
          end else begin
            o.status = ST_RANGE;
          end
        end
      endcase
      o.entry_total = fill_level;
      return o;
    endfunction

    function void note_request(req_t r);
      due_results.push_back(table_outcome(r));
    endfunction

    function int due_count();
      return due_results.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with no transaction pending", got));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.found !== want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.count_value !== want.count_value)
        report($sformatf("count_value %h, want %h", got.count_value, want.count_value));
      if (got.key_at_index !== want.key_at_index)
        report($sformatf("key_at_index %h, want %h", got.key_at_index, want.key_at_index));
      if (got.entry_total !== want.entry_total)
        report($sformatf("entry_total %0d, want %0d", got.entry_total, want.entry_total));
    endtask
  endclass

  logic         clk;
  logic         rst     = 1'b1;
  logic         start   = 1'b0;
  req_t         request = '0;
  logic         busy;
  logic         done;
  res_t         result;
  int           stall_cycles = 0;
  logic [15:0]  key_pool [POOL_SIZE];
  table_tracker sb = new();

  keyed_count_table_top uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(request);
      if (done) sb.check_result(result);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic req_t make_req(op_t op, logic [15:0] key, logic [15:0] amt,
                                    logic [5:0] idx);
    req_t r;
    r.operation   = op;
    r.item_key    = key;
    r.amount      = amt;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic logic [15:0] random_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 40) return 16'($urandom_range(1, 15));
    if (r < 70) return 16'($urandom);
    if (r < 85) return 16'hFFFF;
    return 16'($urandom_range(16'h8000, 16'hFFFF));
  endfunction

  function automatic req_t random_request(phase_t kind, int span);
    req_t r;
    int   pick;
    int   add_cut;
    int   rem_cut;
    int   qry_cut;
    case (kind)
      PHASE_FILL:  begin add_cut = 70; rem_cut = 78; qry_cut = 89; end
      PHASE_DRAIN: begin add_cut = 15; rem_cut = 70; qry_cut = 85; end
      default:     begin add_cut = 35; rem_cut = 60; qry_cut = 80; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < add_cut)      r.operation = OP_ADD;
    else if (pick < rem_cut) r.operation = OP_REMOVE;
    else if (pick < qry_cut) r.operation = OP_QUERY;
    else                     r.operation = OP_READ;
    if ($urandom_range(0, 9) == 0) r.item_key = 16'($urandom);
    else r.item_key = key_pool[$urandom_range(0, span - 1)];
    r.amount = random_amount();
    // aim reads at occupied slots or just past them half the time
    if ($urandom_range(0, 1) == 0) r.entry_index = 6'($urandom_range(0, 63));
    else r.entry_index = 6'($urandom_range(0, sb.fill_level));
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task send(req_t r);
    request <= r;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every pending transaction has produced its result
  task settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  initial begin
    phase_t plan [PHASE_COUNT];
    int     span;
    int     gap;
    bit     no_gaps;
    plan = '{PHASE_FILL, PHASE_DRAIN, PHASE_MIXED, PHASE_FILL,
             PHASE_MIXED, PHASE_DRAIN, PHASE_FILL, PHASE_DRAIN};
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send(make_req(OP_QUERY,  16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_REMOVE, 16'h0005, 16'h0003, 6'd0));
    send(make_req(OP_READ,   16'h0000, 16'h0000, 6'd0));
    // zero amounts, saturation
    send(make_req(OP_ADD,    16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_ADD,    16'h0000, 16'h0001, 6'd0));
    send(make_req(OP_ADD,    16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_ADD,    16'hFFFF, 16'hFFFF, 6'd63));
    send(make_req(OP_ADD,    16'hFFFF, 16'h0001, 6'd0));
    send(make_req(OP_ADD,    16'h0000, 16'hFFFF, 6'd0));
    send(make_req(OP_QUERY,  16'hFFFF, 16'h0000, 6'd0));
    send(make_req(OP_READ,   16'h0000, 16'h0000, 6'd1));
    send(make_req(OP_READ,   16'hFFFF, 16'hFFFF, 6'd63));
    // partial removes and deletes with the last entry moving down
    send(make_req(OP_ADD,    16'h1234, 16'h0005, 6'd0));
    send(make_req(OP_REMOVE, 16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_REMOVE, 16'h1234, 16'h0002, 6'd0));
    send(make_req(OP_REMOVE, 16'h0000, 16'hFFFF, 6'd0));
    send(make_req(OP_READ,   16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_REMOVE, 16'h1234, 16'h0007, 6'd0));
    send(make_req(OP_REMOVE, 16'hFFFF, 16'h8000, 6'd0));
    send(make_req(OP_REMOVE, 16'hFFFF, 16'h7FFF, 6'd0));
    send(make_req(OP_READ,   16'h0000, 16'h0000, 6'd0));
    send(make_req(OP_REMOVE, 16'hFFFF, 16'h0000, 6'd0));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case ($urandom_range(0, 2))
        0:       span = 8;
        1:       span = 40;
        default: span = POOL_SIZE;
      endcase
      if (ph == 0) span = POOL_SIZE;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        if (!no_gaps) begin
          gap = pick_gap();
          if (gap > 0) idle(gap);
        end
        send(random_request(plan[ph], span));
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
